/* rtl/sample_dispersion_statistics_defines.svh */
// ----------------------------------------------------------------------------
// Sample dispersion statistics: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_DISPERSION_STATISTICS_DEFINES_SVH
`define SAMPLE_DISPERSION_STATISTICS_DEFINES_SVH

// Same-cycle implication
`define SDS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sds: same-cycle check failed");

// Next-cycle implication
`define SDS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sds: next-cycle check failed");

`endif

/* rtl/sds_pkg.sv */
// ----------------------------------------------------------------------------
// sds_pkg
// Widths, snapshot, result and queue status types, and back-end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sds_pkg;

	localparam int SMP_W   = 32;
	localparam int CNT_W   = 17;
	localparam int SUM_W   = 48;
	localparam int SQ_W    = 80;
	localparam int PROD_W  = 64;
	localparam int ACC_W   = 97;
	localparam int MPL_W   = 48;
	localparam int RAD_W   = 128;
	localparam int ROOT_W  = 64;
	localparam int REM_W   = 67;
	localparam int DVD_W   = 64;
	localparam int STEP_W  = 6;
	localparam int FRAC_W  = 16;
	localparam int CV_W    = 24;
	localparam int WIDE_W  = 33;
	localparam int MINR_W  = 17;
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = 2;
	localparam int QFILL_W = 3;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic [SUM_W-1:0] sum;
		logic [SQ_W-1:0]  sq;
		logic [SMP_W-1:0] mn;
		logic [SMP_W-1:0] mx;
		logic             ovf;
	} snapshot_t;

	typedef struct packed {
		logic [CV_W-1:0]   cv;
		logic [WIDE_W-1:0] spread;
		logic [MINR_W-1:0] mnr;
		logic [WIDE_W-1:0] mxr;
		logic              mean_pos;
		logic              ovf;
	} result_t;

	typedef struct packed {
		logic empty;
		logic almost_full;
	} queue_status_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MNQ,
		B_MSS,
		B_SQRT,
		B_DCV,
		B_MSP,
		B_DSP,
		B_MMN,
		B_DMN,
		B_MMX,
		B_DMX,
		B_OUT
	} back_state_t;

endpackage

/* rtl/sample_dispersion_statistics.sv */
// ----------------------------------------------------------------------------
// sample_dispersion_statistics
// Count, sum, sum of squares, min and max of a sample set, reported as
// coefficient of variation, spread, min and max ratios over the mean.
// ----------------------------------------------------------------------------
//  channel  | signals                              | transfer
//  sample   | sample_valid, sample_stall           | valid && !stall
//  result   | result_valid, result_stall           | valid && !stall
//
//  The front takes one sample per cycle with no stall of its own.
//  A set with zero sum goes straight from idle to the output state;
//  otherwise the back end runs shift-add multiplies of up to 17 and 48 steps,
//  64 square-root steps and up to four 64-step divisions, all in one sequencer.
//  sample_stall rises while three or more finished sets wait in the four-entry queue.
//  Reset clears all accumulators; no clearing pass is needed.
`timescale 1ns / 1ps

module sample_dispersion_statistics #(
	parameter int MAX_SAMPLES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [31:0] sample,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [23:0] cv_ratio,
	output logic [32:0] spread_ratio,
	output logic [16:0] min_ratio,
	output logic [32:0] max_ratio,
	output logic        mean_positive,
	output logic        count_overflow
);

	logic                   accept;
	logic                   push;
	logic                   pop;
	sds_pkg::snapshot_t     push_data;
	sds_pkg::snapshot_t     pop_data;
	sds_pkg::queue_status_t qstat;
	sds_pkg::result_t       res;

	// Accept while the queue has room for the set in flight
	assign sample_stall = qstat.almost_full;
	assign accept       = sample_valid & ~sample_stall;

	sds_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (sample),
		.last      (last),
		.push      (push),
		.push_data (push_data)
	);

	sds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (qstat)
	);

	sds_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.qstat        (qstat),
		.pop_data     (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.res          (res)
	);

	assign cv_ratio       = res.cv;
	assign spread_ratio   = res.spread;
	assign min_ratio      = res.mnr;
	assign max_ratio      = res.mxr;
	assign mean_positive  = res.mean_pos;
	assign count_overflow = res.ovf;

endmodule

/* rtl/sds_front.sv */
// ----------------------------------------------------------------------------
// sds_front
// Accumulates count, sum, sum of squares, min and max one sample per cycle
// and hands a snapshot of the set to the queue on the last sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_front #(
	parameter int MAX_SAMPLES = 65536
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [sds_pkg::SMP_W-1:0] sample,
	input  logic                     last,
	output logic                     push,
	output sds_pkg::snapshot_t       push_data
);

	logic [sds_pkg::CNT_W-1:0]  count_q;
	logic [sds_pkg::SMP_W-1:0]  min_q;
	logic [sds_pkg::SMP_W-1:0]  max_q;
	logic                       ovf_q;
	logic [sds_pkg::SUM_W-1:0]  sum_q;
	logic [sds_pkg::SQ_W-1:0]   sq_q;

	logic                       valid_s1;
	logic                       last_s1;
	logic                       take_s1;
	logic [sds_pkg::SMP_W-1:0]  smp_s1;
	logic [sds_pkg::PROD_W-1:0] prod_s1;
	logic [sds_pkg::CNT_W-1:0]  cnt_s1;
	logic [sds_pkg::SMP_W-1:0]  mn_s1;
	logic [sds_pkg::SMP_W-1:0]  mx_s1;
	logic                       ovf_s1;

	logic                       take;
	logic [sds_pkg::CNT_W-1:0]  cnt_nx;
	logic [sds_pkg::SMP_W-1:0]  mn_nx;
	logic [sds_pkg::SMP_W-1:0]  mx_nx;
	logic                       ovf_nx;
	logic [sds_pkg::SUM_W-1:0]  sum_nx;
	logic [sds_pkg::SQ_W-1:0]   sq_nx;

	// Classify the sample against the count limit
	always_comb begin
		take   = count_q < sds_pkg::CNT_W'(MAX_SAMPLES);
		cnt_nx = take ? count_q + 1'b1 : count_q;
		mn_nx  = (take && sample < min_q) ? sample : min_q;
		mx_nx  = (take && sample > max_q) ? sample : max_q;
		ovf_nx = ovf_q | ~take;
	end

	// Advance count, min, max and overflow at the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			min_q    <= '1;
			max_q    <= '0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last) begin
					count_q <= '0;
					min_q   <= '1;
					max_q   <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= cnt_nx;
					min_q   <= mn_nx;
					max_q   <= mx_nx;
					ovf_q   <= ovf_nx;
				end
			end
		end
	end

	// Register the sample, its square and the set's closing values
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last;
			take_s1 <= take;
			smp_s1  <= sample;
			prod_s1 <= sds_pkg::PROD_W'(sample) * sds_pkg::PROD_W'(sample);
			cnt_s1  <= cnt_nx;
			mn_s1   <= mn_nx;
			mx_s1   <= mx_nx;
			ovf_s1  <= ovf_nx;
		end
	end

	// Add the registered sample and square into the sums
	always_comb begin
		sum_nx = sum_q + (take_s1 ? sds_pkg::SUM_W'(smp_s1) : '0);
		sq_nx  = sq_q + (take_s1 ? sds_pkg::SQ_W'(prod_s1) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			sq_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_q <= '0;
				sq_q  <= '0;
			end else begin
				sum_q <= sum_nx;
				sq_q  <= sq_nx;
			end
		end
	end

	// Hand the finished set to the queue
	assign push           = valid_s1 & last_s1;
	assign push_data.cnt  = cnt_s1;
	assign push_data.sum  = sum_nx;
	assign push_data.sq   = sq_nx;
	assign push_data.mn   = mn_s1;
	assign push_data.mx   = mx_s1;
	assign push_data.ovf  = ovf_s1;

endmodule

/* rtl/sds_queue.sv */
// ----------------------------------------------------------------------------
// sds_queue
// Short queue of set snapshots between the accumulating front and the
// arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sds_pkg::snapshot_t     push_data,
	input  logic                   pop,
	output sds_pkg::snapshot_t     pop_data,
	output sds_pkg::queue_status_t status
);

	sds_pkg::snapshot_t          mem_q [sds_pkg::Q_DEPTH];
	logic [sds_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [sds_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [sds_pkg::QFILL_W-1:0] fill_q;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	// One slot is kept for the set still inside the front's pipeline
	assign pop_data           = mem_q[rd_ptr_q];
	assign status.empty       = (fill_q == '0);
	assign status.almost_full = (fill_q >= sds_pkg::QFILL_W'(sds_pkg::Q_DEPTH - 1));

endmodule

/* rtl/sds_back.sv */
// ----------------------------------------------------------------------------
// sds_back
// Sequencer over a shift-add multiplier, a bit-pair square root and a
// restoring divider that turns one set snapshot into the four ratios.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sds_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sds_pkg::queue_status_t qstat,
	input  sds_pkg::snapshot_t     pop_data,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output sds_pkg::result_t       res
);

	localparam logic [sds_pkg::STEP_W-1:0] STEP_LAST = '1;

	sds_pkg::back_state_t state_q, state_nx;
	logic                 out_valid_q;
	logic                 res_load;

	sds_pkg::snapshot_t          snap_q;
	logic [sds_pkg::ACC_W-1:0]   acc_q;
	logic [sds_pkg::ACC_W-1:0]   mcand_q;
	logic [sds_pkg::MPL_W-1:0]   mpl_q;
	logic [sds_pkg::ACC_W-1:0]   nq_q;
	logic [sds_pkg::RAD_W-1:0]   rad_q;
	logic [sds_pkg::REM_W-1:0]   rem_q;
	logic [sds_pkg::ROOT_W-1:0]  root_q;
	logic [sds_pkg::DVD_W-1:0]   dvd_q;
	logic [sds_pkg::SUM_W-1:0]   drem_q;
	logic [sds_pkg::STEP_W-1:0]  step_q;
	logic [sds_pkg::CV_W-1:0]    cv_q;
	logic [sds_pkg::WIDE_W-1:0]  spread_q;
	logic [sds_pkg::MINR_W-1:0]  mnr_q;
	logic [sds_pkg::WIDE_W-1:0]  mxr_q;
	sds_pkg::result_t            res_q;

	logic [sds_pkg::ACC_W-1:0]   acc_nx;
	logic [sds_pkg::ACC_W-1:0]   diff;
	logic                        var_ok;
	logic [sds_pkg::REM_W-1:0]   rem_sh;
	logic [sds_pkg::REM_W-1:0]   trial;
	logic                        sq_ge;
	logic [sds_pkg::REM_W-1:0]   rem_nx;
	logic [sds_pkg::ROOT_W-1:0]  root_nx;
	logic [sds_pkg::SUM_W:0]     dr;
	logic                        dv_ge;
	logic [sds_pkg::SUM_W:0]     dr_sub;
	logic [sds_pkg::SUM_W-1:0]   drem_nx;
	logic [sds_pkg::DVD_W-1:0]   quo_nx;
	logic [sds_pkg::CV_W-1:0]    cv_sat;
	logic [sds_pkg::SMP_W-1:0]   range_v;
	logic                        mul_done;
	logic                        step_end;

	// Multiplier, root and divider steps
	always_comb begin
		acc_nx   = acc_q + (mpl_q[0] ? mcand_q : '0);
		mul_done = (mpl_q == '0);
		step_end = (step_q == STEP_LAST);
		diff     = nq_q - acc_q;
		var_ok   = (nq_q >= acc_q);
		range_v  = snap_q.mx - snap_q.mn;

		rem_sh  = {rem_q[sds_pkg::REM_W-3:0], rad_q[sds_pkg::RAD_W-1 -: 2]};
		trial   = sds_pkg::REM_W'({root_q, 2'b01});
		sq_ge   = (rem_sh >= trial);
		rem_nx  = sq_ge ? rem_sh - trial : rem_sh;
		root_nx = {root_q[sds_pkg::ROOT_W-2:0], sq_ge};

		dr      = {drem_q, dvd_q[sds_pkg::DVD_W-1]};
		dv_ge   = (dr >= {1'b0, snap_q.sum});
		dr_sub  = dr - {1'b0, snap_q.sum};
		drem_nx = dv_ge ? dr_sub[sds_pkg::SUM_W-1:0] : dr[sds_pkg::SUM_W-1:0];
		quo_nx  = {dvd_q[sds_pkg::DVD_W-2:0], dv_ge};
		cv_sat  = (|quo_nx[sds_pkg::DVD_W-1:sds_pkg::CV_W]) ? '1 : quo_nx[sds_pkg::CV_W-1:0];
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			sds_pkg::B_IDLE: begin
				if (!qstat.empty) begin
					state_nx = (pop_data.sum == '0) ? sds_pkg::B_OUT : sds_pkg::B_MNQ;
				end
			end
			sds_pkg::B_MNQ: if (mul_done) state_nx = sds_pkg::B_MSS;
			sds_pkg::B_MSS: begin
				if (mul_done) begin
					state_nx = var_ok ? sds_pkg::B_SQRT : sds_pkg::B_MSP;
				end
			end
			sds_pkg::B_SQRT: if (step_end) state_nx = sds_pkg::B_DCV;
			sds_pkg::B_DCV:  if (step_end) state_nx = sds_pkg::B_MSP;
			sds_pkg::B_MSP:  if (mul_done) state_nx = sds_pkg::B_DSP;
			sds_pkg::B_DSP:  if (step_end) state_nx = sds_pkg::B_MMN;
			sds_pkg::B_MMN:  if (mul_done) state_nx = sds_pkg::B_DMN;
			sds_pkg::B_DMN:  if (step_end) state_nx = sds_pkg::B_MMX;
			sds_pkg::B_MMX:  if (mul_done) state_nx = sds_pkg::B_DMX;
			sds_pkg::B_DMX:  if (step_end) state_nx = sds_pkg::B_OUT;
			sds_pkg::B_OUT:  if (!out_valid_q || !result_stall) state_nx = sds_pkg::B_IDLE;
			default:         state_nx = sds_pkg::B_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		pop      = 1'b0;
		res_load = 1'b0;
		case (state_q)
			sds_pkg::B_IDLE: pop      = ~qstat.empty;
			sds_pkg::B_OUT:  res_load = ~out_valid_q | ~result_stall;
			default: begin
				pop      = 1'b0;
				res_load = 1'b0;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sds_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sds_pkg::B_IDLE: begin
				if (pop) begin
					snap_q   <= pop_data;
					acc_q    <= '0;
					mcand_q  <= sds_pkg::ACC_W'(pop_data.sq);
					mpl_q    <= sds_pkg::MPL_W'(pop_data.cnt);
					cv_q     <= '0;
					spread_q <= '0;
					mnr_q    <= '0;
					mxr_q    <= '0;
				end
			end
			sds_pkg::B_MNQ: begin
				if (!mul_done) begin
					acc_q   <= acc_nx;
					mcand_q <= mcand_q << 1;
					mpl_q   <= mpl_q >> 1;
				end else begin
					nq_q    <= acc_q;
					acc_q   <= '0;
					mcand_q <= sds_pkg::ACC_W'(snap_q.sum);
					mpl_q   <= snap_q.sum;
				end
			end
			sds_pkg::B_MSS: begin
				if (!mul_done) begin
					acc_q   <= acc_nx;
					mcand_q <= mcand_q << 1;
					mpl_q   <= mpl_q >> 1;
				end else begin
					rad_q   <= {diff[95:0], 32'b0};
					rem_q   <= '0;
					root_q  <= '0;
					step_q  <= '0;
					acc_q   <= '0;
					mcand_q <= sds_pkg::ACC_W'(range_v);
					mpl_q   <= sds_pkg::MPL_W'(snap_q.cnt);
				end
			end
			sds_pkg::B_SQRT: begin
				rem_q  <= rem_nx;
				root_q <= root_nx;
				rad_q  <= rad_q << 2;
				step_q <= step_q + 1'b1;
				if (step_end) begin
					dvd_q  <= root_nx;
					drem_q <= '0;
				end
			end
			sds_pkg::B_DCV: begin
				dvd_q  <= quo_nx;
				drem_q <= drem_nx;
				step_q <= step_q + 1'b1;
				if (step_end) begin
					cv_q <= cv_sat;
				end
			end
			sds_pkg::B_MSP, sds_pkg::B_MMN, sds_pkg::B_MMX: begin
				if (!mul_done) begin
					acc_q   <= acc_nx;
					mcand_q <= mcand_q << 1;
					mpl_q   <= mpl_q >> 1;
				end else begin
					dvd_q  <= {acc_q[sds_pkg::SUM_W-1:0], {sds_pkg::FRAC_W{1'b0}}};
					drem_q <= '0;
					step_q <= '0;
				end
			end
			sds_pkg::B_DSP, sds_pkg::B_DMN, sds_pkg::B_DMX: begin
				dvd_q  <= quo_nx;
				drem_q <= drem_nx;
				step_q <= step_q + 1'b1;
				if (step_end) begin
					acc_q <= '0;
					mpl_q <= sds_pkg::MPL_W'(snap_q.cnt);
					if (state_q == sds_pkg::B_DSP) begin
						spread_q <= quo_nx[sds_pkg::WIDE_W-1:0];
						mcand_q  <= sds_pkg::ACC_W'(snap_q.mn);
					end else if (state_q == sds_pkg::B_DMN) begin
						mnr_q   <= quo_nx[sds_pkg::MINR_W-1:0];
						mcand_q <= sds_pkg::ACC_W'(snap_q.mx);
					end else begin
						mxr_q <= quo_nx[sds_pkg::WIDE_W-1:0];
					end
				end
			end
			sds_pkg::B_OUT: begin
				if (res_load) begin
					res_q.cv       <= cv_q;
					res_q.spread   <= spread_q;
					res_q.mnr      <= mnr_q;
					res_q.mxr      <= mxr_q;
					res_q.mean_pos <= (snap_q.sum != '0);
					res_q.ovf      <= snap_q.ovf;
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign res          = res_q;

endmodule

/* rtl/sds_checker.sv */
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sample_dispersion_statistics_defines.svh"

module sds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [23:0] cv_ratio,
	input logic [32:0] spread_ratio,
	input logic [16:0] min_ratio,
	input logic [32:0] max_ratio,
	input logic        mean_positive
);

	// Hold a stalled result
	`SDS_ASSERT_NEXT(a_hold, result_valid && result_stall, result_valid)

	// Zero ratios when the mean is zero
	`SDS_ASSERT_SAME(a_zero, result_valid && !mean_positive, cv_ratio == 24'd0 && spread_ratio == 33'd0 && min_ratio == 17'd0 && max_ratio == 33'd0)

	// Min over mean never exceeds one
	`SDS_ASSERT_SAME(a_min_le_one, result_valid, min_ratio <= 17'h10000)

	// Max ratio is at least the min ratio
	`SDS_ASSERT_SAME(a_order, result_valid, max_ratio >= {16'd0, min_ratio})

endmodule

bind sample_dispersion_statistics sds_checker u_checker (.*);

/* bench/tb_sample_dispersion_statistics.sv */
// ----------------------------------------------------------------------------
// tb_sample_dispersion_statistics
// Self-checking bench: streams sample sets through the block, predicts each
// set's ratios in exact wide integers and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sample_dispersion_statistics;

	localparam int MAX_N      = 65536;
	localparam int CYCLE_CAP  = 1000000;
	localparam int DRAIN_WAIT = 1200;
	localparam int HOLD_LEN   = 4000;
	localparam int HOLD_AT    = 30;

	typedef struct {
		logic [31:0] value;
		logic        tail;
	} item_t;

	logic        clk;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_stall;
	logic [31:0] sample;
	logic        last;
	logic        result_valid;
	logic        result_stall;
	logic [23:0] cv_ratio;
	logic [32:0] spread_ratio;
	logic [16:0] min_ratio;
	logic [32:0] max_ratio;
	logic        mean_positive;
	logic        count_overflow;

	item_t            pending[$];
	sds_pkg::result_t ratios_due[$];
	int               errors;
	int               cycles;
	int               results_seen;
	int               hold_left;
	bit               hold_done;

	// running set statistics of the predictor
	logic [16:0]  acc_cnt;
	logic [47:0]  acc_sum;
	logic [127:0] acc_sq;
	logic [31:0]  acc_min;
	logic [31:0]  acc_max;
	logic         acc_ovf;

	sample_dispersion_statistics uut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] isqrt128(input logic [127:0] num);
		logic [127:0] res;
		logic [127:0] bitv;
		res  = 0;
		bitv = 128'd1 << 126;
		while (bitv > num && bitv != 0)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (num >= res + bitv) begin
				num = num - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res[63:0];
	endfunction

	task automatic clear_set();
		acc_cnt = 0;
		acc_sum = 0;
		acc_sq  = 0;
		acc_min = '1;
		acc_max = 0;
		acc_ovf = 0;
	endtask

	// fold one accepted sample in; on the tail, queue the set's ratios
	task automatic accumulate(input logic [31:0] v, input logic tail);
		sds_pkg::result_t r;
		logic [127:0]     nq, ss, d, sh;
		logic [63:0]      n, s, root, cv, w;
		if (acc_cnt < MAX_N) begin
			acc_sq  = acc_sq + 128'(64'(v) * 64'(v));
			acc_sum = acc_sum + 48'(v);
			acc_cnt = acc_cnt + 1;
			if (v < acc_min) acc_min = v;
			if (v > acc_max) acc_max = v;
		end else begin
			acc_ovf = 1;
		end
		if (!tail) return;
		n = 64'(acc_cnt);
		s = 64'(acc_sum);
		r = '0;
		if (s != 0) begin
			nq = acc_sq * 128'(n);
			ss = 128'(s) * 128'(s);
			if (nq >= ss) begin
				d    = nq - ss;
				sh   = d << 32;
				root = isqrt128(sh);
				cv   = root / s;
				r.cv = (cv > 64'hFFFFFF) ? 24'hFFFFFF : cv[23:0];
			end
			w        = (64'(acc_max - acc_min) * n) << 16;
			w        = w / s;
			r.spread = w[32:0];
			w        = ((64'(acc_min) * n) << 16) / s;
			r.mnr    = w[16:0];
			w        = ((64'(acc_max) * n) << 16) / s;
			r.mxr    = w[32:0];
		end
		r.mean_pos = (s != 0);
		r.ovf      = acc_ovf;
		ratios_due.push_back(r);
		clear_set();
	endtask

	function automatic logic [31:0] pick_value();
		int k;
		k = $urandom_range(99);
		if (k < 25) return $urandom;
		if (k < 45) return $urandom_range(255);
		if (k < 65) return 32'hFFFFFFFF - $urandom_range(255);
		if (k < 75) return 0;
		return $urandom >> $urandom_range(31);
	endfunction

	task automatic add_set(input int len);
		for (int i = 0; i < len; i++)
			pending.push_back('{pick_value(), i == len - 1});
	endtask

	task automatic add_item(input logic [31:0] v, input logic tail);
		pending.push_back('{v, tail});
	endtask

	// drive sample transfers; predict at each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 0;
			sample       <= 0;
			last         <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				accumulate(sample, last);
				void'(pending.pop_front());
			end
			if (!(sample_valid && sample_stall)) begin
				if (pending.size() > 0 &&
				    ((cycles > 2000 && cycles < 8000) || $urandom_range(99) >= 11)) begin
					sample       <= pending[0].value;
					last         <= pending[0].tail;
					sample_valid <= 1;
				end else begin
					sample_valid <= 0;
				end
			end
		end
	end

	// check result transfers and drive the receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 0;
			hold_left    <= 0;
			hold_done    <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (ratios_due.size() == 0) begin
					$display("%0t: unexpected result cv=%h", $time, cv_ratio);
					errors++;
				end else begin
					if (cv_ratio !== ratios_due[0].cv) begin
						$display("%0t: cv_ratio exp %h got %h", $time,
							ratios_due[0].cv, cv_ratio);
						errors++;
					end
					if (spread_ratio !== ratios_due[0].spread) begin
						$display("%0t: spread_ratio exp %h got %h", $time,
							ratios_due[0].spread, spread_ratio);
						errors++;
					end
					if (min_ratio !== ratios_due[0].mnr) begin
						$display("%0t: min_ratio exp %h got %h", $time,
							ratios_due[0].mnr, min_ratio);
						errors++;
					end
					if (max_ratio !== ratios_due[0].mxr) begin
						$display("%0t: max_ratio exp %h got %h", $time,
							ratios_due[0].mxr, max_ratio);
						errors++;
					end
					if (mean_positive !== ratios_due[0].mean_pos) begin
						$display("%0t: mean_positive exp %b got %b", $time,
							ratios_due[0].mean_pos, mean_positive);
						errors++;
					end
					if (count_overflow !== ratios_due[0].ovf) begin
						$display("%0t: count_overflow exp %b got %b", $time,
							ratios_due[0].ovf, count_overflow);
						errors++;
					end
					void'(ratios_due.pop_front());
				end
				results_seen <= results_seen + 1;
			end
			// long hold-off once so the result queue fills and stalls input
			if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				result_stall <= 1;
			end else if (!hold_done && results_seen == HOLD_AT) begin
				hold_done    <= 1;
				hold_left    <= HOLD_LEN;
				result_stall <= 1;
			end else begin
				result_stall <= ((cycles > 2000 && cycles < 8000) ? 1'b0 :
					($urandom_range(99) < 11));
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int len;
		errors       = 0;
		cycles       = 0;
		results_seen = 0;
		clear_set();
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: zero sum, extremes, single samples, high dispersion
		add_item(0, 1);
		add_item(0, 0); add_item(0, 1);
		add_item(32'hFFFFFFFF, 1);
		add_item(32'hFFFFFFFF, 0); add_item(0, 1);
		add_item(1, 0);
		for (int i = 0; i < 6; i++) add_item(0, 0);
		add_item(0, 1);
		for (int i = 0; i < 3; i++) add_item(32'hFFFFFFFF, 0);
		add_item(0, 1);
		add_item(32'h55555555, 0); add_item(32'hAAAAAAAA, 1);
		add_item(7, 0); add_item(7, 0); add_item(7, 1);

		// random sets, mostly short
		len = 0;
		while (len < 430) begin
			int sz;
			sz = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
			add_set(sz);
			len += sz;
		end

		wait (pending.size() == 0 && !sample_valid);
		wait (ratios_due.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sample_dispersion_statistics.f */
+incdir+rtl
rtl/sds_pkg.sv
rtl/sds_front.sv
rtl/sds_queue.sv
rtl/sds_back.sv
rtl/sample_dispersion_statistics.sv
rtl/sds_checker.sv
bench/tb_sample_dispersion_statistics.sv
